@@ sv/dfra_pkg.sv @@
// ----------------------------------------------------------------------------
// dfra_pkg
// Shared codes, control structs and float helpers for the double FPU ALU.
// ----------------------------------------------------------------------------
package dfra_pkg;

	localparam int NREG      = 8;
	localparam int RIDX_W    = $clog2(NREG);
	localparam int MUL_ITERS = 53;
	localparam int DIV_ITERS = 56;
	localparam int CNT_W     = 6;

	localparam logic [3:0] ACT_MOVE = 4'd0;
	localparam logic [3:0] ACT_ADD  = 4'd1;
	localparam logic [3:0] ACT_SUB  = 4'd2;
	localparam logic [3:0] ACT_MUL  = 4'd3;
	localparam logic [3:0] ACT_DIV  = 4'd4;
	localparam logic [3:0] ACT_CMP  = 4'd5;
	localparam logic [3:0] ACT_TEST = 4'd6;
	localparam logic [3:0] ACT_LOAD = 4'd7;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DIVZ  = 2'd1;
	localparam logic [1:0] ST_BADOP = 2'd2;

	localparam logic [1:0] KIND_FIN = 2'd0;
	localparam logic [1:0] KIND_ADD = 2'd1;
	localparam logic [1:0] KIND_MD  = 2'd2;

	localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
	localparam logic [10:0] EXP_MAX   = 11'h7FF;

	typedef struct packed {
		logic capture;
		logic classify;
		logic align;
		logic pre;
		logic iter;
		logic mdload;
		logic norm;
		logic round;
		logic wb;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       pre_done;
		logic       norm_done;
		logic       is_div;
	} stat_t;

	typedef struct packed {
		logic [31:0] last_address;
		logic        divzero_sticky;
		logic        cond_nan;
		logic        cond_infinity;
		logic        cond_zero;
		logic        cond_negative;
		logic [63:0] result_bits;
		logic [1:0]  status;
	} res_t;

	function automatic logic is_nan(input logic [63:0] b);
		return (b[62:52] == EXP_MAX) && (b[51:0] != 52'd0);
	endfunction

	function automatic logic is_zero(input logic [63:0] b);
		return b[62:0] == 63'd0;
	endfunction

	function automatic logic is_inf(input logic [63:0] b);
		return (b[62:52] == EXP_MAX) && (b[51:0] == 52'd0);
	endfunction

	// bit 0 negative, bit 1 zero, bit 2 infinity, bit 3 NaN
	function automatic logic [3:0] flags_of(input logic [63:0] b);
		logic [3:0] f;
		f = 4'd0;
		if (is_nan(b)) begin
			f[3] = 1'b1;
		end else if (is_zero(b)) begin
			f[1] = 1'b1;
		end else begin
			f[0] = b[63];
			f[2] = is_inf(b);
		end
		return f;
	endfunction

endpackage

@@ sv/double_fpu_register_alu_top.sv @@
// ----------------------------------------------------------------------------
// double_fpu_register_alu_top
// Eight-register IEEE double FPU with condition flags, stream in and out.
// ----------------------------------------------------------------------------
// One request at a time; each returns one result. Move, test, load, invalid
// operations, divide by zero and special operands (NaN, infinity, zero) go
// from classification straight to write-back. Add, subtract and compare pass
// through alignment, normalization and rounding; cancellation adds steps.
// Multiply and divide prenormalize, iterate, normalize and round: the shared
// shift-add multiplier retires one bit per cycle over the 53 significand bits,
// the restoring divider one quotient bit per cycle over 56 quotient bits.
// Subnormal operands add prenormalization steps, and a carry out or a
// subnormal result adds normalization steps. A finished result sits in an output
// register, so the next request is accepted while it waits; the result after
// it holds until the first one is taken.
module double_fpu_register_alu_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// action[3:0], dst_index[6:4], src_index[9:7], instruction_address[41:10],
	// load_value[105:42], zero fill[111:106]
	input  logic [111:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// status[1:0], result_bits[65:2], cond_negative[66], cond_zero[67],
	// cond_infinity[68], cond_nan[69], divzero_sticky[70], last_address[102:71],
	// zero fill[103]
	output logic [103:0]  m_tdata
);

	dfra_pkg::cmd_t  cmd;
	dfra_pkg::stat_t stat;
	dfra_pkg::res_t  res;
	dfra_pkg::res_t  out_q;
	logic            out_vld_q;
	logic            push;

	dfra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.out_full (out_vld_q),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd),
		.push     (push)
	);

	dfra_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.action              (s_tdata[3:0]),
		.dst_index           (s_tdata[6:4]),
		.src_index           (s_tdata[9:7]),
		.instruction_address (s_tdata[41:10]),
		.load_value          (s_tdata[105:42]),
		.stat                (stat),
		.res                 (res)
	);

	always_ff @(posedge clk) begin
		if (push) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (push) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_q};

endmodule

@@ sv/dfra_ctrl.sv @@
// ----------------------------------------------------------------------------
// dfra_ctrl
// Sequencer for one request: read, classify, align or prenormalize and iterate, normalize, round, write back.
// ----------------------------------------------------------------------------
module dfra_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic            out_full,
	input  logic            m_tready,
	input  dfra_pkg::stat_t stat,
	output dfra_pkg::cmd_t  cmd,
	output logic            push
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_CLASS = 4'd2;
	localparam logic [3:0] S_ALIGN = 4'd3;
	localparam logic [3:0] S_PRE   = 4'd4;
	localparam logic [3:0] S_ITER  = 4'd5;
	localparam logic [3:0] S_MDLD  = 4'd6;
	localparam logic [3:0] S_NORM  = 4'd7;
	localparam logic [3:0] S_ROUND = 4'd8;
	localparam logic [3:0] S_WB    = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0]                 state_q, state_d;
	logic [dfra_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_last;

	assign s_tready = (state_q == S_IDLE);
	assign push     = (state_q == S_DONE) && (!out_full || m_tready);
	assign cnt_last = stat.is_div ? dfra_pkg::CNT_W'(dfra_pkg::DIV_ITERS - 1)
		: dfra_pkg::CNT_W'(dfra_pkg::MUL_ITERS - 1);

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == S_IDLE) && s_tvalid;
		cmd.classify = (state_q == S_CLASS);
		cmd.align    = (state_q == S_ALIGN);
		cmd.pre      = (state_q == S_PRE);
		cmd.iter     = (state_q == S_ITER);
		cmd.mdload   = (state_q == S_MDLD);
		cmd.norm     = (state_q == S_NORM);
		cmd.round    = (state_q == S_ROUND);
		cmd.wb       = (state_q == S_WB);
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_RD;
			end
			S_RD: state_d = S_CLASS;
			S_CLASS: begin
				case (stat.kind)
					dfra_pkg::KIND_ADD: state_d = S_ALIGN;
					dfra_pkg::KIND_MD:  state_d = S_PRE;
					default:            state_d = S_WB;
				endcase
			end
			S_ALIGN: state_d = S_NORM;
			S_PRE: begin
				cnt_d = '0;
				if (stat.pre_done) state_d = S_ITER;
			end
			S_ITER: begin
				if (cnt_q == cnt_last) begin
					state_d = S_MDLD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_MDLD: state_d = S_NORM;
			S_NORM: begin
				if (stat.norm_done) state_d = S_ROUND;
			end
			S_ROUND: state_d = S_WB;
			S_WB:    state_d = S_DONE;
			S_DONE: begin
				if (push) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

@@ sv/dfra_dp.sv @@
// ----------------------------------------------------------------------------
// dfra_dp
// Register file, flags and shared add / multiply / divide / round datapath.
// ----------------------------------------------------------------------------
module dfra_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dfra_pkg::cmd_t               cmd,
	input  logic [3:0]                   action,
	input  logic [dfra_pkg::RIDX_W-1:0]  dst_index,
	input  logic [dfra_pkg::RIDX_W-1:0]  src_index,
	input  logic [31:0]                  instruction_address,
	input  logic [63:0]                  load_value,
	output dfra_pkg::stat_t              stat,
	output dfra_pkg::res_t               res
);

	logic [63:0]                 rf_mem [dfra_pkg::NREG];
	logic [dfra_pkg::NREG-1:0]   rf_vld_q;
	logic [63:0]                 lb_raw_q, rb_raw_q;
	logic                        lb_vld_q, rb_vld_q;
	logic [63:0]                 lb, rb;

	logic [3:0]                  act_q;
	logic [dfra_pkg::RIDX_W-1:0] dst_q, src_q;
	logic [31:0]                 addr_q, addr_lat_q;
	logic [63:0]                 ldv_q, res_q;
	logic                        wr_q, flg_q, s_q, es_q;
	logic [1:0]                  st_q;
	logic [3:0]                  flags_q;
	logic                        sticky_q;

	logic [52:0]                 opa_sig_q, opb_sig_q;
	logic signed [13:0]          opa_e_q, opb_e_q;
	logic [105:0]                acc_q;
	logic [53:0]                 rem_q;
	logic [55:0]                 quo_q;
	logic [56:0]                 m_q;
	logic signed [13:0]          e_q;

	logic                        sa, sb, sbe, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
	logic [52:0]                 sig_a, sig_b;
	logic signed [13:0]          ee_a, ee_b;
	logic                        a_ge, swp;
	logic [63:0]                 c_res;
	logic                        c_wr, c_flg, c_sign;
	logic [1:0]                  c_st, c_kind;

	logic signed [13:0]          d14;
	logic [5:0]                  d6;
	logic [55:0]                 ext_b, msk, al_sh, big;
	logic                        al_stk;
	logic [56:0]                 al_sum;

	logic [52:0]                 pa_sig, pb_sig;
	logic signed [13:0]          pa_e, pb_e;

	logic [53:0]                 mul_sum;
	logic [54:0]                 div_diff;
	logic                        div_ge;
	logic [53:0]                 div_r;

	logic [56:0]                 n_m;
	logic signed [13:0]          n_e;
	logic                        n_done;

	logic                        r_inc, r_carry;
	logic [53:0]                 r_sig54;
	logic [52:0]                 r_sig;
	logic signed [13:0]          r_e2;
	logic [10:0]                 r_ef;
	logic [63:0]                 r_res;

	assign lb = lb_vld_q ? lb_raw_q : 64'd0;
	assign rb = rb_vld_q ? rb_raw_q : 64'd0;

	always_ff @(posedge clk) begin
		lb_raw_q <= rf_mem[dst_q];
		rb_raw_q <= rf_mem[src_q];
		if (cmd.wb && wr_q) rf_mem[dst_q] <= res_q;
	end

	// operand classification
	assign sa     = lb[63];
	assign sb     = rb[63];
	assign sbe    = sb ^ ((act_q == dfra_pkg::ACT_SUB) || (act_q == dfra_pkg::ACT_CMP));
	assign nan_a  = dfra_pkg::is_nan(lb);
	assign nan_b  = dfra_pkg::is_nan(rb);
	assign inf_a  = dfra_pkg::is_inf(lb);
	assign inf_b  = dfra_pkg::is_inf(rb);
	assign zero_a = dfra_pkg::is_zero(lb);
	assign zero_b = dfra_pkg::is_zero(rb);
	assign sig_a  = {lb[62:52] != 11'd0, lb[51:0]};
	assign sig_b  = {rb[62:52] != 11'd0, rb[51:0]};
	assign ee_a   = (lb[62:52] == 11'd0) ? 14'sd1 : $signed({3'b000, lb[62:52]});
	assign ee_b   = (rb[62:52] == 11'd0) ? 14'sd1 : $signed({3'b000, rb[62:52]});
	assign a_ge   = lb[62:0] >= rb[62:0];

	always_comb begin
		c_res  = lb;
		c_wr   = 1'b0;
		c_flg  = 1'b1;
		c_st   = dfra_pkg::ST_OK;
		c_kind = dfra_pkg::KIND_FIN;
		c_sign = sa ^ sb;
		swp    = 1'b0;
		case (act_q)
			dfra_pkg::ACT_MOVE: begin
				c_res = rb;
				c_wr  = 1'b1;
			end
			dfra_pkg::ACT_ADD, dfra_pkg::ACT_SUB, dfra_pkg::ACT_CMP: begin
				c_wr   = (act_q != dfra_pkg::ACT_CMP);
				swp    = !a_ge;
				c_sign = a_ge ? sa : sbe;
				if (nan_a || nan_b || (inf_a && inf_b && (sa != sbe))) begin
					c_res = dfra_pkg::CANON_NAN;
				end else if (inf_a) begin
					c_res = lb;
				end else if (inf_b) begin
					c_res = {sbe, rb[62:0]};
				end else begin
					c_kind = dfra_pkg::KIND_ADD;
				end
			end
			dfra_pkg::ACT_MUL: begin
				c_wr = 1'b1;
				if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
					c_res = dfra_pkg::CANON_NAN;
				end else if (inf_a || inf_b) begin
					c_res = {sa ^ sb, dfra_pkg::EXP_MAX, 52'd0};
				end else if (zero_a || zero_b) begin
					c_res = {sa ^ sb, 63'd0};
				end else begin
					c_kind = dfra_pkg::KIND_MD;
				end
			end
			dfra_pkg::ACT_DIV: begin
				if (zero_b) begin
					c_st = dfra_pkg::ST_DIVZ;
				end else begin
					c_wr = 1'b1;
					if (nan_a || nan_b || (inf_a && inf_b)) begin
						c_res = dfra_pkg::CANON_NAN;
					end else if (inf_a) begin
						c_res = {sa ^ sb, dfra_pkg::EXP_MAX, 52'd0};
					end else if (inf_b || zero_a) begin
						c_res = {sa ^ sb, 63'd0};
					end else begin
						c_kind = dfra_pkg::KIND_MD;
					end
				end
			end
			dfra_pkg::ACT_TEST: c_res = lb;
			dfra_pkg::ACT_LOAD: begin
				c_res = ldv_q;
				c_wr  = 1'b1;
				c_flg = 1'b0;
			end
			default: begin
				c_flg = 1'b0;
				c_st  = dfra_pkg::ST_BADOP;
			end
		endcase
	end

	// alignment add / subtract
	assign d14    = opa_e_q - opb_e_q;
	assign d6     = d14[5:0];
	assign ext_b  = {opb_sig_q, 3'b000};
	assign msk    = ~({56{1'b1}} << d6);
	assign al_stk = |(ext_b & msk);
	assign al_sh  = (d14 > 14'sd55) ? {55'd0, |opb_sig_q}
		: ((ext_b >> d6) | {55'd0, al_stk});
	assign big    = {opa_sig_q, 3'b000};
	assign al_sum = es_q ? ({1'b0, big} - {1'b0, al_sh}) : ({1'b0, big} + {1'b0, al_sh});

	// operand prenormalization
	always_comb begin
		pa_sig = opa_sig_q;
		pa_e   = opa_e_q;
		pb_sig = opb_sig_q;
		pb_e   = opb_e_q;
		if (!opa_sig_q[52]) begin
			if (opa_sig_q[52:37] == 16'd0) begin
				pa_sig = opa_sig_q << 16;
				pa_e   = opa_e_q - 14'sd16;
			end else begin
				pa_sig = opa_sig_q << 1;
				pa_e   = opa_e_q - 14'sd1;
			end
		end
		if (!opb_sig_q[52]) begin
			if (opb_sig_q[52:37] == 16'd0) begin
				pb_sig = opb_sig_q << 16;
				pb_e   = opb_e_q - 14'sd16;
			end else begin
				pb_sig = opb_sig_q << 1;
				pb_e   = opb_e_q - 14'sd1;
			end
		end
	end

	// shift-add multiply and restoring divide steps
	assign mul_sum  = {1'b0, acc_q[105:53]} + (opb_sig_q[0] ? {1'b0, opa_sig_q} : 54'd0);
	assign div_diff = {1'b0, rem_q} - {2'b00, opb_sig_q};
	assign div_ge   = !div_diff[54];
	assign div_r    = div_ge ? div_diff[53:0] : rem_q;

	// normalization step
	always_comb begin
		n_m    = m_q;
		n_e    = e_q;
		n_done = 1'b0;
		if (m_q[56]) begin
			n_m = {1'b0, m_q[56:2], m_q[1] | m_q[0]};
			n_e = e_q + 14'sd1;
		end else if (m_q == 57'd0) begin
			n_done = 1'b1;
		end else if (e_q < 14'sd1) begin
			if (e_q < -14'sd70) begin
				n_m = 57'd1;
				n_e = 14'sd1;
			end else if (e_q <= -14'sd15) begin
				n_m = {16'd0, m_q[56:17], m_q[16] | (|m_q[15:0])};
				n_e = e_q + 14'sd16;
			end else begin
				n_m = {1'b0, m_q[56:2], m_q[1] | m_q[0]};
				n_e = e_q + 14'sd1;
			end
		end else if (!m_q[55] && (e_q > 14'sd1)) begin
			if ((m_q[55:40] == 16'd0) && (e_q > 14'sd16)) begin
				n_m = m_q << 16;
				n_e = e_q - 14'sd16;
			end else begin
				n_m = m_q << 1;
				n_e = e_q - 14'sd1;
			end
		end else begin
			n_done = 1'b1;
		end
	end

	// round to nearest even and pack
	assign r_inc   = m_q[2] & (m_q[3] | m_q[1] | m_q[0]);
	assign r_sig54 = {1'b0, m_q[55:3]} + {53'd0, r_inc};
	assign r_carry = r_sig54[53];
	assign r_sig   = r_carry ? r_sig54[53:1] : r_sig54[52:0];
	assign r_e2    = e_q + $signed({13'd0, r_carry});
	assign r_ef    = r_sig[52] ? r_e2[10:0] : 11'd0;
	assign r_res   = (r_e2 > 14'sd2046) ? {s_q, dfra_pkg::EXP_MAX, 52'd0}
		: {s_q, r_ef, r_sig[51:0]};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= action;
			dst_q  <= dst_index;
			src_q  <= src_index;
			addr_q <= instruction_address;
			ldv_q  <= load_value;
		end
		if (cmd.classify) begin
			res_q     <= c_res;
			wr_q      <= c_wr;
			flg_q     <= c_flg;
			st_q      <= c_st;
			s_q       <= c_sign;
			es_q      <= sa ^ sbe;
			opa_sig_q <= swp ? sig_b : sig_a;
			opa_e_q   <= swp ? ee_b : ee_a;
			opb_sig_q <= swp ? sig_a : sig_b;
			opb_e_q   <= swp ? ee_a : ee_b;
			acc_q     <= '0;
		end
		if (cmd.align) begin
			m_q <= al_sum;
			e_q <= opa_e_q;
			if ((al_sum == 57'd0) && es_q) s_q <= 1'b0;
		end
		if (cmd.pre) begin
			if (stat.pre_done) begin
				rem_q <= {1'b0, opa_sig_q};
				quo_q <= '0;
			end else begin
				opa_sig_q <= pa_sig;
				opa_e_q   <= pa_e;
				opb_sig_q <= pb_sig;
				opb_e_q   <= pb_e;
			end
		end
		if (cmd.iter) begin
			if (stat.is_div) begin
				rem_q <= {div_r[52:0], 1'b0};
				quo_q <= {quo_q[54:0], div_ge};
			end else begin
				acc_q     <= {mul_sum, acc_q[52:1]};
				opb_sig_q <= {1'b0, opb_sig_q[52:1]};
			end
		end
		if (cmd.mdload) begin
			if (stat.is_div) begin
				m_q <= {1'b0, quo_q[55:1], quo_q[0] | (|rem_q)};
				e_q <= opa_e_q - opb_e_q + 14'sd1023;
			end else begin
				m_q <= {acc_q[105:50], acc_q[49] | (|acc_q[48:0])};
				e_q <= opa_e_q + opb_e_q - 14'sd1023;
			end
		end
		if (cmd.norm) begin
			m_q <= n_m;
			e_q <= n_e;
		end
		if (cmd.round) res_q <= r_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q   <= '0;
			lb_vld_q   <= 1'b0;
			rb_vld_q   <= 1'b0;
			flags_q    <= 4'd0;
			sticky_q   <= 1'b0;
			addr_lat_q <= 32'd0;
		end else begin
			lb_vld_q <= rf_vld_q[dst_q];
			rb_vld_q <= rf_vld_q[src_q];
			if (cmd.wb) begin
				if (wr_q) rf_vld_q[dst_q] <= 1'b1;
				if (flg_q) flags_q <= dfra_pkg::flags_of(res_q);
				if (st_q == dfra_pkg::ST_DIVZ) sticky_q <= 1'b1;
				if (act_q != dfra_pkg::ACT_LOAD) addr_lat_q <= addr_q;
			end
		end
	end

	assign stat.kind      = c_kind;
	assign stat.pre_done  = opa_sig_q[52] & opb_sig_q[52];
	assign stat.norm_done = n_done;
	assign stat.is_div    = (act_q == dfra_pkg::ACT_DIV);

	assign res.status         = st_q;
	assign res.result_bits    = wr_q ? res_q : lb;
	assign res.cond_negative  = flags_q[0];
	assign res.cond_zero      = flags_q[1];
	assign res.cond_infinity  = flags_q[2];
	assign res.cond_nan       = flags_q[3];
	assign res.divzero_sticky = sticky_q;
	assign res.last_address   = addr_lat_q;

endmodule
